FILE: hw/rtl/synf_pkg.sv
`timescale 1ns / 1ps
// Package for the SYN flood filter: verdict codes, header constants,
// packed request layout and table entry format. No dependencies.
package synf_pkg;

   localparam int ReqDataWidth  = 80;
   localparam int RspDataWidth  = 8;
   localparam int AddrWidth     = 32;
   localparam int CountWidth    = 32;
   localparam int LenWidth      = 16;

   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [7:0]  ProtoTcp      = 8'd6;
   localparam logic [16:0] EthBytes      = 17'd14;
   localparam logic [16:0] Ipv4MinBytes  = 17'd20;
   localparam logic [16:0] TcpMinBytes   = 17'd20;
   localparam logic [3:0]  IhlMin        = 4'd5;

   typedef enum logic [1:0] {
      VERDICT_PASS  = 2'd0,
      VERDICT_DROP  = 2'd1,
      VERDICT_ABORT = 2'd2
   } verdict_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_MISS = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   // one table entry as stored in the RAM
   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic [AddrWidth-1:0]  addr;
   } entry_type;

   // request word, last field in the lowest bits
   typedef struct packed {
      logic [1:0]            pad;
      logic [AddrWidth-1:0]  dest_addr;
      logic                  tcp_ack;
      logic                  tcp_syn;
      logic [7:0]            ip_protocol;
      logic [3:0]            ip_header_words;
      logic [15:0]           ether_type;
      logic [LenWidth-1:0]   frame_length;
   } req_word_type;

endpackage

FILE: hw/rtl/synf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module synf_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/syn_flood_packet_filter_top.sv
`timescale 1ns / 1ps
// Top level of the SYN flood filter: header checks, table scan and update.
// Depends on synf_pkg and synf_ram.
//
// Usage:
//   req_* carries one parsed frame header per word (length, ether type, IHL,
//   protocol, SYN, ACK, destination address). rsp_* returns one verdict per
//   request: 0 pass, 1 drop, 2 abort (malformed). csr_wr_en/csr_wr_data load
//   the flood threshold; write it only while the filter is idle.
// Flow:
//   A frame settled by its header checks alone goes from acceptance to the
//   emit state and then into the output register. A TCP SYN/ACK frame scans
//   the destination table one entry per cycle from the lowest slot, since
//   the table RAM has one read port, until a match or the last stored
//   destination; on a miss it passes through the miss state before emit.
//   One request is in work at a time.
// Reset:
//   Clears the fill count (the table is empty), the threshold and the output
//   register. Slots fill from the bottom and are never freed, so the fill
//   count marks the valid entries; no clearing pass is needed.
// Backpressure:
//   The verdict sits in an output register; a new request is accepted while
//   it waits. If a second verdict is ready before the first is taken, the
//   filter holds it and stalls req_tready until rsp_tready frees the register.
module syn_flood_packet_filter_top #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic        clock,
   input  logic        reset,
   // frame_length[15:0], ether_type[31:16], ip_header_words[35:32],
   // ip_protocol[43:36], tcp_syn[44], tcp_ack[45], dest_addr[77:46], zero pad
   input  logic [synf_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // verdict[1:0], zero pad
   output logic [synf_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FillW = IdxW + 1;
   localparam int EntryW = $bits(synf_pkg::entry_type);

   synf_pkg::req_word_type req_word;
   assign req_word = synf_pkg::req_word_type'(req_tdata);

   // control state
   synf_pkg::state_type state_ff, state_in;
   logic [FillW-1:0]   fill_ff, fill_in;
   logic [31:0]        thr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   // payload
   synf_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;
   synf_pkg::verdict_type verdict_ff, verdict_in;
   logic [IdxW-1:0]    scan_idx_ff, scan_idx_in;
   logic [31:0]        addr_ff, addr_in;
   logic               ack_ff, ack_in;

   // table RAM
   logic                 ram_wr_en;
   logic [IdxW-1:0]      ram_wr_addr;
   synf_pkg::entry_type  ram_wr_entry;
   logic [IdxW-1:0]      ram_rd_addr;
   logic [EntryW-1:0]    ram_rd_data;
   synf_pkg::entry_type  rd_entry;

   synf_ram #(
      .WIDTH (EntryW),
      .DEPTH (TABLE_ENTRIES),
      .ADDR_W(IdxW)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rd_entry = synf_pkg::entry_type'(ram_rd_data);

   // header checks on the incoming word
   logic [16:0] len_ext;
   logic [16:0] ip_bytes;
   logic [16:0] ip_end;
   logic        needs_table;
   synf_pkg::verdict_type early_verdict;

   always_comb begin
      len_ext  = {1'b0, req_word.frame_length};
      ip_bytes = {11'd0, req_word.ip_header_words, 2'b00};
      ip_end   = synf_pkg::EthBytes + ip_bytes;
      needs_table   = 1'b0;
      early_verdict = synf_pkg::VERDICT_PASS;
      priority if (len_ext < synf_pkg::EthBytes) begin
         early_verdict = synf_pkg::VERDICT_ABORT;
      end else if (req_word.ether_type != synf_pkg::EtherTypeIpv4) begin
         early_verdict = synf_pkg::VERDICT_PASS;
      end else if (len_ext < synf_pkg::EthBytes + synf_pkg::Ipv4MinBytes) begin
         early_verdict = synf_pkg::VERDICT_ABORT;
      end else if (req_word.ip_header_words < synf_pkg::IhlMin) begin
         early_verdict = synf_pkg::VERDICT_ABORT;
      end else if (ip_end > len_ext) begin
         early_verdict = synf_pkg::VERDICT_ABORT;
      end else if (req_word.ip_protocol != synf_pkg::ProtoTcp) begin
         early_verdict = synf_pkg::VERDICT_PASS;
      end else if (ip_end + synf_pkg::TcpMinBytes > len_ext) begin
         early_verdict = synf_pkg::VERDICT_ABORT;
      end else if (!req_word.tcp_syn && !req_word.tcp_ack) begin
         early_verdict = synf_pkg::VERDICT_PASS;
      end else begin
         needs_table = 1'b1;
      end
   end

   // hit path arithmetic
   logic [31:0] hit_count;
   logic        hit;
   logic        last_slot;
   logic        out_free;
   logic        table_full;

   always_comb begin
      hit = (rd_entry.addr == addr_ff);
      last_slot = ({1'b0, scan_idx_ff} + FillW'(1)) == fill_ff;
      out_free = !rsp_valid_ff || rsp_tready;
      table_full = (fill_ff == FillW'(TABLE_ENTRIES));
      if (ack_ff) begin
         // ACK closes a handshake: count down, floor at zero
         hit_count = (rd_entry.count != 32'd0) ? rd_entry.count - 32'd1 : 32'd0;
      end else begin
         // SYN only: count up, saturate
         hit_count = (rd_entry.count != '1) ? rd_entry.count + 32'd1 : rd_entry.count;
      end
   end

   assign req_tready = (state_ff == synf_pkg::ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      verdict_in     = verdict_ff;
      scan_idx_in    = scan_idx_ff;
      addr_in        = addr_ff;
      ack_in         = ack_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_verdict_in = rsp_verdict_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = scan_idx_ff;
      ram_wr_entry   = '{count: hit_count, addr: addr_ff};
      ram_rd_addr    = scan_idx_ff + IdxW'(1);

      unique case (state_ff)
         synf_pkg::ST_IDLE: begin
            ram_rd_addr = '0;
            if (req_tvalid) begin
               addr_in     = req_word.dest_addr;
               ack_in      = req_word.tcp_ack;
               scan_idx_in = '0;
               verdict_in  = early_verdict;
               if (!needs_table) begin
                  state_in = synf_pkg::ST_EMIT;
               end else if (fill_ff == '0) begin
                  state_in = synf_pkg::ST_MISS;
               end else begin
                  state_in = synf_pkg::ST_SCAN;
               end
            end
         end
         synf_pkg::ST_SCAN: begin
            // read data belongs to scan_idx_ff; next slot is already requested
            if (hit) begin
               ram_wr_en = 1'b1;
               if (ack_ff || hit_count <= thr_ff) begin
                  verdict_in = synf_pkg::VERDICT_PASS;
               end else begin
                  verdict_in = synf_pkg::VERDICT_DROP;
               end
               state_in = synf_pkg::ST_EMIT;
            end else if (last_slot) begin
               state_in = synf_pkg::ST_MISS;
            end else begin
               scan_idx_in = scan_idx_ff + IdxW'(1);
            end
         end
         synf_pkg::ST_MISS: begin
            if (thr_ff == 32'd0) begin
               verdict_in = synf_pkg::VERDICT_DROP;
            end else begin
               verdict_in = synf_pkg::VERDICT_PASS;
               // new SYN destination: take the lowest free slot if any
               if (!ack_ff && !table_full) begin
                  ram_wr_en    = 1'b1;
                  ram_wr_addr  = fill_ff[IdxW-1:0];
                  ram_wr_entry = '{count: 32'd1, addr: addr_ff};
                  fill_in      = fill_ff + FillW'(1);
               end
            end
            state_in = synf_pkg::ST_EMIT;
         end
         synf_pkg::ST_EMIT: begin
            // hold the verdict until the output register is free
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               state_in       = synf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = synf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= synf_pkg::ST_IDLE;
         fill_ff      <= '0;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff     <= verdict_in;
      scan_idx_ff    <= scan_idx_in;
      addr_ff        <= addr_in;
      ack_ff         <= ack_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(synf_pkg::RspDataWidth - 2){1'b0}}, rsp_verdict_ff};

   // fill count never passes the table size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(TABLE_ENTRIES))
      else $error("table fill count beyond table size");

   // fill grows by at most one slot per cycle
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      ##1 (fill_ff == $past(fill_ff) || fill_ff == $past(fill_ff) + FillW'(1)))
      else $error("table fill count jumped");

   // table writes happen only while resolving a lookup
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == synf_pkg::ST_SCAN || state_ff == synf_pkg::ST_MISS))
      else $error("table write outside lookup");

   // a verdict leaving the emit state lands in the output register
   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == synf_pkg::ST_EMIT && out_free) |=>
         (rsp_valid_ff && rsp_verdict_ff == $past(verdict_ff)))
      else $error("verdict not loaded into output register");

endmodule
